// ----- hw/rtl/tgarle_pkg.sv -----
// tgarle_pkg: shared constants, packet mode codes and structs of the targa rle line encoder
// used by every module of the encoder but tgarle_ram, depends on nothing
package tgarle_pkg;

  // packet and result geometry
  localparam int unsigned MAX_PACKET        = 128;
  localparam int unsigned PIXELS_PER_RESULT = 4;
  localparam int unsigned PIX_W             = 24;
  localparam int unsigned LINE_W            = 16;
  localparam int unsigned PCNT_W            = 3;
  localparam int unsigned CNT_W             = $clog2(MAX_PACKET + 1);
  localparam int unsigned IDX_W             = $clog2(MAX_PACKET);
  localparam int unsigned LANE_W            = $clog2(PIXELS_PER_RESULT);
  localparam int unsigned ITEM_W            = IDX_W - LANE_W;

  // raw buffer: two halves, split into one bank per result lane
  localparam int unsigned BANK_AW    = ITEM_W + 1;
  localparam int unsigned BANK_DEPTH = 2 ** BANK_AW;

  // descriptor queue between front and back
  localparam int unsigned DESC_DEPTH = 4;
  localparam int unsigned DESC_PW    = $clog2(DESC_DEPTH);
  localparam int unsigned DESC_CW    = $clog2(DESC_DEPTH + 1);

  localparam logic [LINE_W-1:0] LINE_WIDTH_RESET = 16'd640;

  // packet mode of the front end
  typedef enum logic [2:0] {
    MODE_EMPTY = 3'b001,
    MODE_RAW   = 3'b010,
    MODE_RUN   = 3'b100
  } mode_e;

  // one closed packet, as handed from front to back
  typedef struct packed {
    logic              is_run;
    logic              uses_buf;
    logic              slot;
    logic [IDX_W-1:0]  cnt_m1;
    logic [PIX_W-1:0]  pixel;
    logic              last;
  } desc_t;

  // up to two packets close on one pixel
  typedef struct packed {
    logic  v0;
    logic  v1;
    desc_t d0;
    desc_t d1;
  } desc_push_t;

  // raw buffer write from the front
  typedef struct packed {
    logic             en;
    logic             slot;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] data;
  } buf_wr_t;

  // buffer half handed back once its last read is issued
  typedef struct packed {
    logic en;
    logic slot;
  } buf_rel_t;

endpackage

// ----- hw/rtl/tga_rle_line_encoder.sv -----
// tga_rle_line_encoder: top level of the 24-bit targa rle scanline encoder
// depends on tgarle_pkg, tgarle_ram, tgarle_front, tgarle_desc_fifo, tgarle_back
//
// channel   direction  handshake        payload
// config    in         cfg_we_i         cfg_wdata_i (line width, 0 = 65536)
// pixels    in         push / full      pixel_value_i
// results   out        pop / empty      has_header_o .. last_of_step_o
//
// one pixel is taken per cycle while the descriptor queue has room for two packets
// and the other half of the raw buffer is free. after a raw packet of n >= 2 pixels
// closes, input waits until the back end has issued its ceil(n/4) buffer reads, behind
// packets already queued. reads and result words go one per cycle while pop is high.
// reset clears all control state; the raw buffer needs no clearing pass.
module tga_rle_line_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [23:0] pixel_value_i,
  output logic        empty,
  input  logic        pop,
  output logic        has_header_o,
  output logic [7:0]  packet_header_o,
  output logic [2:0]  pixel_count_o,
  output logic [23:0] pixel_first_o,
  output logic [23:0] pixel_second_o,
  output logic [23:0] pixel_third_o,
  output logic [23:0] pixel_fourth_o,
  output logic        last_of_step_o
);

  tgarle_pkg::desc_push_t                desc_push;
  tgarle_pkg::buf_wr_t                   buf_wr;
  tgarle_pkg::buf_rel_t                  buf_rel;
  tgarle_pkg::desc_t                     head;
  logic                                  head_valid;
  logic                                  head_pop;
  logic [tgarle_pkg::DESC_CW-1:0]        fifo_count;
  logic                                  rd_en;
  logic [tgarle_pkg::BANK_AW-1:0]        rd_addr;
  logic [tgarle_pkg::PIXELS_PER_RESULT-1:0][tgarle_pkg::PIX_W-1:0] rdata;
  logic [tgarle_pkg::PIXELS_PER_RESULT-1:0][tgarle_pkg::PIX_W-1:0] pixels;

  // front: classification and raw buffer writes
  tgarle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_i        (push),
    .pixel_value_i (pixel_value_i),
    .full_o        (full),
    .fifo_count_i  (fifo_count),
    .push_o        (desc_push),
    .wr_o          (buf_wr),
    .rel_i         (buf_rel)
  );

  // descriptor queue
  tgarle_desc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .pop_i   (head_pop),
    .head_o  (head),
    .valid_o (head_valid),
    .count_o (fifo_count)
  );

  // raw buffer, one bank per result lane
  for (genvar b = 0; b < tgarle_pkg::PIXELS_PER_RESULT; b++) begin : g_bank
    tgarle_ram #(
      .Width (tgarle_pkg::PIX_W),
      .Depth (tgarle_pkg::BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (buf_wr.en && (buf_wr.idx[tgarle_pkg::LANE_W-1:0] == tgarle_pkg::LANE_W'(b))),
      .waddr_i ({buf_wr.slot, buf_wr.idx[tgarle_pkg::IDX_W-1:tgarle_pkg::LANE_W]}),
      .wdata_i (buf_wr.data),
      .re_i    (rd_en),
      .raddr_i (rd_addr),
      .rdata_o (rdata[b])
    );
  end

  // back: result words
  tgarle_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_valid_i    (head_valid),
    .head_pop_o      (head_pop),
    .rel_o           (buf_rel),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rdata_i         (rdata),
    .empty_o         (empty),
    .pop_i           (pop),
    .has_header_o    (has_header_o),
    .packet_header_o (packet_header_o),
    .pixel_count_o   (pixel_count_o),
    .pixels_o        (pixels),
    .last_of_step_o  (last_of_step_o)
  );

  assign pixel_first_o  = pixels[0];
  assign pixel_second_o = pixels[1];
  assign pixel_third_o  = pixels[2];
  assign pixel_fourth_o = pixels[3];

`ifndef SYNTHESIS
  // a waiting word carries one to four pixels
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pixel_count_o != 3'd0)
               && (pixel_count_o <= 3'(tgarle_pkg::PIXELS_PER_RESULT)))
    else $error("result word pixel count out of range");

  // a run header comes with exactly one pixel
  a_run_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && has_header_o && packet_header_o[7]) |-> (pixel_count_o == 3'd1))
    else $error("run packet word carries more than one pixel");

  // continuation words carry no header
  a_no_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_header_o) |-> (packet_header_o == 8'd0))
    else $error("continuation word carries a header");

  // the descriptor queue never overfills
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= tgarle_pkg::DESC_CW'(tgarle_pkg::DESC_DEPTH))
    else $error("descriptor queue overflow");
`endif

endmodule

// ----- hw/rtl/tgarle_ram.sv -----
// tgarle_ram: generic single write port, single read port ram with registered read
// no dependencies
module tgarle_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/tgarle_front.sv -----
// tgarle_front: takes pixels, tracks the open packet and the line column, writes raw pixels
// and pushes closed packets as descriptors; depends on tgarle_pkg
module tgarle_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tgarle_pkg::LINE_W-1:0]  cfg_wdata_i,
  input  logic                           push_i,
  input  logic [tgarle_pkg::PIX_W-1:0]   pixel_value_i,
  output logic                           full_o,
  input  logic [tgarle_pkg::DESC_CW-1:0] fifo_count_i,
  output tgarle_pkg::desc_push_t         push_o,
  output tgarle_pkg::buf_wr_t            wr_o,
  input  tgarle_pkg::buf_rel_t           rel_i
);

  tgarle_pkg::mode_e                mode_q, mode_d;
  logic [tgarle_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [tgarle_pkg::PIX_W-1:0]     prev_q, prev_d;
  logic [tgarle_pkg::LINE_W-1:0]    col_q, col_d;
  logic [tgarle_pkg::LINE_W-1:0]    width_q;
  logic                             slot_q, slot_d;
  logic [1:0]                       busy_q, busy_d;

  logic                             accept;
  logic                             same;
  logic                             eol;
  logic [tgarle_pkg::LINE_W:0]      col_inc;
  logic [tgarle_pkg::LINE_W:0]      width_lim;
  logic                             open_pkt;
  logic                             emit_a;
  logic                             emit_b;
  tgarle_pkg::desc_t                desc_a;
  tgarle_pkg::desc_t                desc_b;

  // stall while the queue lacks room for two packets or the other buffer half still drains
  assign full_o = busy_q[~slot_q]
                  || (fifo_count_i > tgarle_pkg::DESC_CW'(tgarle_pkg::DESC_DEPTH - 2));
  assign accept = push_i && !full_o;
  assign same   = (pixel_value_i == prev_q);

  // line end, a zero width means a full 65536 pixel line
  assign col_inc   = {1'b0, col_q} + (tgarle_pkg::LINE_W + 1)'(1);
  assign width_lim = (width_q == '0) ? {1'b1, tgarle_pkg::LINE_W'(0)} : {1'b0, width_q};
  assign eol       = (col_inc >= width_lim);

  // packet classification for one pixel
  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    prev_d   = prev_q;
    slot_d   = slot_q;
    busy_d   = busy_q;
    col_d    = col_q;
    open_pkt = 1'b0;
    emit_a   = 1'b0;
    emit_b   = 1'b0;
    desc_a   = '0;
    desc_b   = '0;
    wr_o     = '0;

    // back end is done with a buffer half
    if (rel_i.en) begin
      busy_d[rel_i.slot] = 1'b0;
    end

    if (accept) begin
      unique case (mode_q)
        tgarle_pkg::MODE_RUN: begin
          if (same) begin
            cnt_d = cnt_q + tgarle_pkg::CNT_W'(1);
          end else begin
            emit_a          = 1'b1;
            desc_a.is_run   = 1'b1;
            desc_a.slot     = slot_q;
            desc_a.cnt_m1   = tgarle_pkg::IDX_W'(cnt_q - tgarle_pkg::CNT_W'(1));
            desc_a.pixel    = prev_q;
            open_pkt        = 1'b1;
          end
        end
        tgarle_pkg::MODE_RAW: begin
          if (same && (cnt_q == tgarle_pkg::CNT_W'(1))) begin
            mode_d = tgarle_pkg::MODE_RUN;
            cnt_d  = tgarle_pkg::CNT_W'(2);
          end else if (same) begin
            // repeated pixel closes the raw packet and opens in the other half
            emit_a          = 1'b1;
            desc_a.uses_buf = 1'b1;
            desc_a.slot     = slot_q;
            desc_a.cnt_m1   = tgarle_pkg::IDX_W'(cnt_q - tgarle_pkg::CNT_W'(1));
            desc_a.pixel    = prev_q;
            busy_d[slot_q]  = 1'b1;
            slot_d          = ~slot_q;
            open_pkt        = 1'b1;
          end else begin
            wr_o.en   = 1'b1;
            wr_o.slot = slot_q;
            wr_o.idx  = cnt_q[tgarle_pkg::IDX_W-1:0];
            wr_o.data = pixel_value_i;
            cnt_d     = cnt_q + tgarle_pkg::CNT_W'(1);
            prev_d    = pixel_value_i;
          end
        end
        tgarle_pkg::MODE_EMPTY: begin
          open_pkt = 1'b1;
        end
        default: begin
          open_pkt = 1'b1;
        end
      endcase

      // new packet starts at this pixel
      if (open_pkt) begin
        mode_d    = tgarle_pkg::MODE_RAW;
        cnt_d     = tgarle_pkg::CNT_W'(1);
        prev_d    = pixel_value_i;
        wr_o.en   = 1'b1;
        wr_o.slot = slot_d;
        wr_o.idx  = '0;
        wr_o.data = pixel_value_i;
      end

      // close at line end or at the packet limit
      emit_b = (mode_d != tgarle_pkg::MODE_EMPTY)
               && (eol || (cnt_d >= tgarle_pkg::CNT_W'(tgarle_pkg::MAX_PACKET)));
      if (emit_b) begin
        desc_b.is_run   = (mode_d == tgarle_pkg::MODE_RUN);
        desc_b.uses_buf = (mode_d == tgarle_pkg::MODE_RAW) && (cnt_d >= tgarle_pkg::CNT_W'(2));
        desc_b.slot     = slot_d;
        desc_b.cnt_m1   = tgarle_pkg::IDX_W'(cnt_d - tgarle_pkg::CNT_W'(1));
        desc_b.pixel    = prev_d;
        desc_b.last     = 1'b1;
        if (desc_b.uses_buf) begin
          busy_d[slot_d] = 1'b1;
          slot_d         = ~slot_d;
        end
        mode_d = tgarle_pkg::MODE_EMPTY;
        cnt_d  = '0;
      end
      desc_a.last = !emit_b;

      col_d = eol ? '0 : col_inc[tgarle_pkg::LINE_W-1:0];
    end
  end

  // descriptors in packet order
  always_comb begin
    push_o = '0;
    if (emit_a) begin
      push_o.v0 = 1'b1;
      push_o.d0 = desc_a;
      push_o.v1 = emit_b;
      push_o.d1 = desc_b;
    end else begin
      push_o.v0 = emit_b;
      push_o.d0 = desc_b;
    end
  end

  // state and line width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tgarle_pkg::MODE_EMPTY;
      cnt_q   <= '0;
      prev_q  <= '0;
      col_q   <= '0;
      slot_q  <= 1'b0;
      busy_q  <= '0;
      width_q <= tgarle_pkg::LINE_WIDTH_RESET;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      prev_q <= prev_d;
      col_q  <= col_d;
      slot_q <= slot_d;
      busy_q <= busy_d;
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ----- hw/rtl/tgarle_desc_fifo.sv -----
// tgarle_desc_fifo: short packet descriptor queue, two writes and one read per cycle
// depends on tgarle_pkg
module tgarle_desc_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tgarle_pkg::desc_push_t         push_i,
  input  logic                           pop_i,
  output tgarle_pkg::desc_t              head_o,
  output logic                           valid_o,
  output logic [tgarle_pkg::DESC_CW-1:0] count_o
);

  tgarle_pkg::desc_t                mem_q [tgarle_pkg::DESC_DEPTH];
  logic [tgarle_pkg::DESC_PW-1:0]   wp_q, wp_d;
  logic [tgarle_pkg::DESC_PW-1:0]   rp_q, rp_d;
  logic [tgarle_pkg::DESC_CW-1:0]   cnt_q, cnt_d;
  logic [tgarle_pkg::DESC_PW-1:0]   wp_next;

  assign wp_next = wp_q + tgarle_pkg::DESC_PW'(1);

  // pointer and fill count update
  always_comb begin
    wp_d  = wp_q + tgarle_pkg::DESC_PW'(push_i.v0) + tgarle_pkg::DESC_PW'(push_i.v1);
    rp_d  = rp_q + tgarle_pkg::DESC_PW'(pop_i);
    cnt_d = cnt_q + tgarle_pkg::DESC_CW'(push_i.v0) + tgarle_pkg::DESC_CW'(push_i.v1)
            - tgarle_pkg::DESC_CW'(pop_i);
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wp_q] <= push_i.d0;
    end
    if (push_i.v1) begin
      mem_q[wp_next] <= push_i.d1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = mem_q[rp_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

endmodule

// ----- hw/rtl/tgarle_back.sv -----
// tgarle_back: turns packet descriptors into result words, reading up to four raw pixels
// per word from the banked buffer; depends on tgarle_pkg
module tgarle_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tgarle_pkg::desc_t             head_i,
  input  logic                          head_valid_i,
  output logic                          head_pop_o,
  output tgarle_pkg::buf_rel_t          rel_o,
  output logic                          rd_en_o,
  output logic [tgarle_pkg::BANK_AW-1:0] rd_addr_o,
  input  logic [tgarle_pkg::PIXELS_PER_RESULT-1:0][tgarle_pkg::PIX_W-1:0] rdata_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic                          has_header_o,
  output logic [7:0]                    packet_header_o,
  output logic [tgarle_pkg::PCNT_W-1:0] pixel_count_o,
  output logic [tgarle_pkg::PIXELS_PER_RESULT-1:0][tgarle_pkg::PIX_W-1:0] pixels_o,
  output logic                          last_of_step_o
);

  typedef struct packed {
    logic                          has_header;
    logic [7:0]                    header;
    logic [tgarle_pkg::PCNT_W-1:0] take;
    logic                          last;
    logic                          uses_buf;
    logic [tgarle_pkg::PIX_W-1:0]  pixel;
  } word_meta_t;

  logic [tgarle_pkg::ITEM_W-1:0] item_q, item_d;
  logic                          valid_q, valid_d;
  word_meta_t                    meta_q, meta_d;
  logic [tgarle_pkg::CNT_W-1:0]  rem;
  logic                          last_item;
  logic [tgarle_pkg::PCNT_W-1:0] take;
  logic                          pop_acc;
  logic                          issue;

  // pixels left in the packet from this word on
  assign rem = tgarle_pkg::CNT_W'({1'b0, head_i.cnt_m1}) + tgarle_pkg::CNT_W'(1)
               - tgarle_pkg::CNT_W'({item_q, tgarle_pkg::LANE_W'(0)});
  assign last_item = !head_i.uses_buf
                     || (rem <= tgarle_pkg::CNT_W'(tgarle_pkg::PIXELS_PER_RESULT));
  assign take = !head_i.uses_buf ? tgarle_pkg::PCNT_W'(1)
              : last_item ? rem[tgarle_pkg::PCNT_W-1:0]
              : tgarle_pkg::PCNT_W'(tgarle_pkg::PIXELS_PER_RESULT);

  // a new word starts when the result register is free or being taken
  assign pop_acc = pop_i && valid_q;
  assign issue   = head_valid_i && (!valid_q || pop_acc);

  assign head_pop_o = issue && last_item;
  assign rel_o.en   = issue && last_item && head_i.uses_buf;
  assign rel_o.slot = head_i.slot;
  assign rd_en_o    = issue && head_i.uses_buf;
  assign rd_addr_o  = {head_i.slot, item_q};

  // word counter and result register
  always_comb begin
    item_d  = item_q;
    valid_d = valid_q;
    meta_d  = meta_q;
    if (issue) begin
      item_d            = last_item ? '0 : item_q + tgarle_pkg::ITEM_W'(1);
      valid_d           = 1'b1;
      meta_d.has_header = (item_q == '0);
      meta_d.header     = (item_q == '0) ? {head_i.is_run, head_i.cnt_m1} : 8'd0;
      meta_d.take       = take;
      meta_d.last       = head_i.last && last_item;
      meta_d.uses_buf   = head_i.uses_buf;
      meta_d.pixel      = head_i.pixel;
    end else if (pop_acc) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      item_q  <= item_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q <= meta_d;
  end

  // result fields, unused lanes read zero
  always_comb begin
    for (int k = 0; k < tgarle_pkg::PIXELS_PER_RESULT; k++) begin
      if (meta_q.uses_buf) begin
        pixels_o[k] = (tgarle_pkg::PCNT_W'(k) < meta_q.take) ? rdata_i[k] : '0;
      end else begin
        pixels_o[k] = (k == 0) ? meta_q.pixel : '0;
      end
    end
  end

  assign empty_o         = !valid_q;
  assign has_header_o    = meta_q.has_header;
  assign packet_header_o = meta_q.header;
  assign pixel_count_o   = meta_q.take;
  assign last_of_step_o  = meta_q.last;

endmodule
